@@ src/cpu_stack_call_return_unit_defines.svh @@
// Assertion macros shared by the stack unit checker.
// No dependencies; include by bare file name.
`ifndef CPU_STACK_CALL_RETURN_UNIT_DEFINES_SVH
`define CPU_STACK_CALL_RETURN_UNIT_DEFINES_SVH

// same-cycle implication
`define CSRU_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("stack unit check failed");

// next-cycle implication
`define CSRU_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("stack unit check failed");

`endif

@@ src/csru_pkg.sv @@
// Package for the stack call/return unit: opcodes, frame layout, helpers.
// No dependencies.
`default_nettype none
package csru_pkg;

  localparam int ADDR_WIDTH_DEFAULT = 16;
  localparam int BYTE_W      = 8;
  localparam int WORD_W      = 16;
  localparam int REG_W       = 64;
  localparam int FRAME_BYTES = 14;
  localparam int FRAME_W     = FRAME_BYTES * BYTE_W;
  localparam int CNT_W       = $clog2(FRAME_BYTES);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAME_BYTES - 1);

  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_CALL = 2'd2,
    OP_RET  = 2'd3
  } op_t;

  function automatic logic [REG_W-1:0] byte_swap(input logic [REG_W-1:0] v);
    logic [REG_W-1:0] r;
    for (int i = 0; i < REG_W / BYTE_W; i++) begin
      r[i*BYTE_W +: BYTE_W] = v[(REG_W/BYTE_W-1-i)*BYTE_W +: BYTE_W];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ src/csru_cmd_if.sv @@
// Request channel of the stack unit: valid/ready plus instruction operands.
// Depends on csru_pkg.
`default_nettype none
interface csru_cmd_if;
  logic                            valid;
  logic                            ready;
  csru_pkg::op_t                   op;
  logic [csru_pkg::BYTE_W-1:0]     push_value;
  logic [csru_pkg::WORD_W-1:0]     call_target;
  logic [csru_pkg::WORD_W-1:0]     current_pc;
  logic [csru_pkg::WORD_W-1:0]     m_pair_in;
  logic [csru_pkg::REG_W-1:0]      gp_regs_in;

  modport source (output valid, op, push_value, call_target, current_pc, m_pair_in,
                  gp_regs_in, input ready);
  modport sink   (input valid, op, push_value, call_target, current_pc, m_pair_in,
                  gp_regs_in, output ready);
endinterface
`default_nettype wire

@@ src/csru_res_if.sv @@
// Result channel of the stack unit: valid/ready plus result fields.
// Depends on csru_pkg.
`default_nettype none
interface csru_res_if;
  logic                            valid;
  logic                            ready;
  logic [csru_pkg::BYTE_W-1:0]     pop_value;
  logic [csru_pkg::WORD_W-1:0]     next_pc;
  logic [csru_pkg::WORD_W-1:0]     m_pair_out;
  logic [csru_pkg::REG_W-1:0]      gp_regs_out;
  logic [csru_pkg::REG_W-1:0]      return_copy;
  logic [csru_pkg::WORD_W-1:0]     stack_pointer_out;
  logic [csru_pkg::WORD_W-1:0]     base_pointer_out;

  modport source (output valid, pop_value, next_pc, m_pair_out, gp_regs_out, return_copy,
                  stack_pointer_out, base_pointer_out, input ready);
  modport sink   (input valid, pop_value, next_pc, m_pair_out, gp_regs_out, return_copy,
                  stack_pointer_out, base_pointer_out, output ready);
endinterface
`default_nettype wire

@@ src/csru_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module csru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ src/cpu_stack_call_return_unit.sv @@
// Stack / call / return unit: push, pop, call frame save, return frame restore.
// Depends on csru_pkg, csru_cmd_if, csru_res_if, csru_ram.
//
//   channel | dir | payload
//   cmd     | in  | op, push_value, call_target, current_pc, m_pair_in, gp_regs_in
//   res     | out | pop_value, next_pc, m_pair_out, gp_regs_out, return_copy,
//           |     | stack_pointer_out, base_pointer_out
//
// One request at a time; every memory byte goes through the single stack RAM.
// cmd.ready rises with result valid, so a new request is taken only after the
// previous one has finished.
// A finished result waits in the res register while the next request is taken.
// rst is synchronous: clears both pointers and the sequencer; the RAM is not cleared.
`default_nettype none
module cpu_stack_call_return_unit #(
  parameter int ADDR_WIDTH = csru_pkg::ADDR_WIDTH_DEFAULT
) (
  input wire logic  clk,
  input wire logic  rst,
  csru_cmd_if.sink  cmd,
  csru_res_if.source res
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_WRITE = 5'b00010,
    S_READ  = 5'b00100,
    S_CAP   = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  localparam int FW = csru_pkg::FRAME_W;
  localparam int BW = csru_pkg::BYTE_W;

  state_t                         state;
  logic [ADDR_WIDTH-1:0]          sp;
  logic [ADDR_WIDTH-1:0]          bp;
  logic [csru_pkg::CNT_W-1:0]     cnt;
  logic [FW-1:0]                  frame;
  csru_pkg::op_t                  op_r;
  logic [csru_pkg::WORD_W-1:0]    tgt_r;
  logic [csru_pkg::WORD_W-1:0]    pc_r;
  logic [csru_pkg::WORD_W-1:0]    mp_r;
  logic [csru_pkg::REG_W-1:0]     gp_r;

  logic [ADDR_WIDTH-1:0]          sp_step;
  logic [BW-1:0]                  rdata;
  logic [csru_pkg::WORD_W-1:0]    bp16;
  logic [csru_pkg::WORD_W-1:0]    ret_bp16;
  logic [ADDR_WIDTH-1:0]          bp_next;
  logic                           accept;
  logic                           res_free;

  assign cmd.ready = (state == S_IDLE);
  assign accept    = cmd.valid && cmd.ready;
  assign res_free  = !res.valid || res.ready;

  assign sp_step  = sp + ((state == S_WRITE) ? {ADDR_WIDTH{1'b1}} : ADDR_WIDTH'(1));
  assign bp16     = csru_pkg::WORD_W'(bp);
  assign ret_bp16 = {frame[103:96], frame[111:104]};

  always_comb begin
    case (op_r)
      csru_pkg::OP_CALL: bp_next = sp;
      csru_pkg::OP_RET:  bp_next = ret_bp16[ADDR_WIDTH-1:0];
      default:           bp_next = bp;
    endcase
  end

  csru_ram #(
    .WIDTH (BW),
    .DEPTH (2 ** ADDR_WIDTH)
  ) u_ram (
    .clk   (clk),
    .we    (state == S_WRITE),
    .waddr (sp_step),
    .wdata (frame[BW-1:0]),
    .re    (state == S_READ),
    .raddr (sp),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      sp        <= '0;
      bp        <= '0;
      cnt       <= '0;
      res.valid <= 1'b0;
    end else begin
      if (state == S_DONE && res_free) begin
        res.valid <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            op_r  <= cmd.op;
            tgt_r <= cmd.call_target;
            pc_r  <= cmd.current_pc;
            mp_r  <= cmd.m_pair_in;
            gp_r  <= cmd.gp_regs_in;
            case (cmd.op)
              csru_pkg::OP_PUSH: begin
                frame <= {{(FW-BW){1'b0}}, cmd.push_value};
                cnt   <= csru_pkg::CNT_LAST;
                state <= S_WRITE;
              end
              csru_pkg::OP_POP: begin
                cnt   <= csru_pkg::CNT_LAST;
                state <= S_READ;
              end
              csru_pkg::OP_CALL: begin
                frame <= {csru_pkg::byte_swap(cmd.gp_regs_in),
                          cmd.m_pair_in[7:0], cmd.m_pair_in[15:8],
                          cmd.current_pc[15:8], cmd.current_pc[7:0],
                          bp16[15:8], bp16[7:0]};
                cnt   <= '0;
                state <= S_WRITE;
              end
              default: begin
                sp    <= bp;
                cnt   <= '0;
                state <= S_READ;
              end
            endcase
          end
        end
        S_WRITE: begin
          sp    <= sp_step;
          frame <= {{BW{1'b0}}, frame[FW-1:BW]};
          cnt   <= cnt + csru_pkg::CNT_W'(1);
          if (cnt == csru_pkg::CNT_LAST) begin
            state <= S_DONE;
          end
        end
        S_READ: begin
          sp  <= sp_step;
          cnt <= cnt + csru_pkg::CNT_W'(1);
          if (cnt != '0) begin
            frame <= {rdata, frame[FW-1:BW]};
          end
          if (cnt == csru_pkg::CNT_LAST) begin
            state <= S_CAP;
          end
        end
        S_CAP: begin
          frame <= {rdata, frame[FW-1:BW]};
          state <= S_DONE;
        end
        S_DONE: begin
          if (res_free) begin
            res.stack_pointer_out <= csru_pkg::WORD_W'(sp);
            res.base_pointer_out  <= csru_pkg::WORD_W'(bp_next);
            bp                    <= bp_next;
            state                 <= S_IDLE;
            case (op_r)
              csru_pkg::OP_PUSH, csru_pkg::OP_CALL: begin
                res.pop_value   <= '0;
                res.next_pc     <= (op_r == csru_pkg::OP_CALL) ? tgt_r : pc_r;
                res.m_pair_out  <= mp_r;
                res.gp_regs_out <= gp_r;
                res.return_copy <= '0;
              end
              csru_pkg::OP_POP: begin
                res.pop_value   <= frame[FW-1 -: BW];
                res.next_pc     <= pc_r;
                res.m_pair_out  <= mp_r;
                res.gp_regs_out <= gp_r;
                res.return_copy <= '0;
              end
              default: begin
                res.pop_value   <= '0;
                res.next_pc     <= {frame[87:80], frame[95:88]};
                res.m_pair_out  <= frame[79:64];
                res.gp_regs_out <= frame[63:0];
                res.return_copy <= gp_r;
              end
            endcase
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ src/csru_checker.sv @@
// Port-level checks for the stack unit, bound to its top level.
// Depends on cpu_stack_call_return_unit_defines.svh and cpu_stack_call_return_unit.
`default_nettype none
`include "cpu_stack_call_return_unit_defines.svh"
module csru_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic cmd_valid,
  input wire logic cmd_ready,
  input wire logic res_valid,
  input wire logic res_ready
);

  `CSRU_ASSERT_NEXT(a_res_hold, clk, rst, res_valid && !res_ready, res_valid)
  `CSRU_ASSERT_NEXT(a_busy_after_request, clk, rst, cmd_valid && cmd_ready, !cmd_ready)
  `CSRU_ASSERT_IMPLY(a_result_while_busy, clk, rst, $rose(res_valid), $past(!cmd_ready))

endmodule

bind cpu_stack_call_return_unit csru_checker u_csru_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd.valid),
  .cmd_ready (cmd.ready),
  .res_valid (res.valid),
  .res_ready (res.ready)
);
`default_nettype wire

@@ tb/cpu_stack_call_return_unit_tb.sv @@
`timescale 1ns / 1ps
// Testbench for cpu_stack_call_return_unit: push, pop, call and return requests
// checked against a shadow stack and pointer pair kept in the bench.
// Depends on csru_pkg, csru_cmd_if, csru_res_if and the unit itself.
module cpu_stack_call_return_unit_tb;

  localparam int BYTE_W           = csru_pkg::BYTE_W;
  localparam int WORD_W           = csru_pkg::WORD_W;
  localparam int REG_W            = csru_pkg::REG_W;
  localparam int FRAME_BYTES      = csru_pkg::FRAME_BYTES;
  localparam int CYCLE_LIMIT      = 2_000_000;
  localparam int STORE_DEPTH      = 1 << 16;
  localparam int RANDOM_BLOCKS    = 13;
  localparam int BLOCK_REQUESTS   = 100;
  localparam int PRESSURE_COUNT   = 30;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES     = 40;

  typedef struct {
    csru_pkg::op_t     op;
    logic [BYTE_W-1:0] push_value;
    logic [WORD_W-1:0] call_target;
    logic [WORD_W-1:0] current_pc;
    logic [WORD_W-1:0] m_pair;
    logic [REG_W-1:0]  gp_regs;
  } stack_req_t;

  typedef struct {
    logic [BYTE_W-1:0] pop_value;
    logic [WORD_W-1:0] next_pc;
    logic [WORD_W-1:0] m_pair;
    logic [REG_W-1:0]  gp_regs;
    logic [REG_W-1:0]  return_copy;
    logic [WORD_W-1:0] stack_pointer;
    logic [WORD_W-1:0] base_pointer;
  } stack_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  csru_cmd_if cmd_ch ();
  csru_res_if res_ch ();

  cpu_stack_call_return_unit DUT (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_ch),
    .res(res_ch)
  );

  logic [BYTE_W-1:0] shadow_stack [STORE_DEPTH];
  bit                shadow_written [STORE_DEPTH];
  logic [WORD_W-1:0] shadow_sp = '0;
  logic [WORD_W-1:0] shadow_bp = '0;
  stack_res_t        pending_results [$];

  int error_count = 0;
  int cycle_count = 0;
  bit source_gaps_on = 1'b1;
  bit sink_stalls_on = 1'b1;
  bit hold_request = 1'b0;

  int loose_bytes = 0;
  int loose_per_frame [$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void shadow_push(logic [BYTE_W-1:0] b);
    shadow_sp = shadow_sp - 16'd1;
    shadow_stack[shadow_sp] = b;
    shadow_written[shadow_sp] = 1'b1;
  endfunction

  function automatic logic [BYTE_W-1:0] shadow_pop();
    logic [BYTE_W-1:0] b;
    b = shadow_stack[shadow_sp];
    shadow_sp = shadow_sp + 16'd1;
    return b;
  endfunction

  function automatic bit stored(logic [WORD_W-1:0] addr, int count);
    logic [WORD_W-1:0] a;
    a = addr;
    for (int i = 0; i < count; i++) begin
      if (!shadow_written[a]) return 1'b0;
      a = a + 16'd1;
    end
    return 1'b1;
  endfunction

  function automatic stack_res_t stack_step(stack_req_t r);
    stack_res_t e;
    e.pop_value   = '0;
    e.next_pc     = r.current_pc;
    e.m_pair      = r.m_pair;
    e.gp_regs     = r.gp_regs;
    e.return_copy = '0;
    case (r.op)
      csru_pkg::OP_PUSH: begin
        shadow_push(r.push_value);
      end
      csru_pkg::OP_POP: begin
        e.pop_value = shadow_pop();
      end
      csru_pkg::OP_CALL: begin
        shadow_push(shadow_bp[7:0]);
        shadow_push(shadow_bp[15:8]);
        shadow_push(r.current_pc[7:0]);
        shadow_push(r.current_pc[15:8]);
        shadow_push(r.m_pair[15:8]);
        shadow_push(r.m_pair[7:0]);
        for (int i = 7; i >= 0; i--) shadow_push(r.gp_regs[i*BYTE_W +: BYTE_W]);
        shadow_bp = shadow_sp;
        e.next_pc = r.call_target;
      end
      csru_pkg::OP_RET: begin
        e.return_copy = r.gp_regs;
        shadow_sp = shadow_bp;
        for (int i = 0; i < 8; i++) e.gp_regs[i*BYTE_W +: BYTE_W] = shadow_pop();
        e.m_pair[7:0]   = shadow_pop();
        e.m_pair[15:8]  = shadow_pop();
        e.next_pc[15:8] = shadow_pop();
        e.next_pc[7:0]  = shadow_pop();
        shadow_bp[15:8] = shadow_pop();
        shadow_bp[7:0]  = shadow_pop();
      end
      default: begin
      end
    endcase
    e.stack_pointer = shadow_sp;
    e.base_pointer  = shadow_bp;
    return e;
  endfunction

  function automatic stack_req_t make_req(csru_pkg::op_t op, logic [BYTE_W-1:0] pv,
                                          logic [WORD_W-1:0] tgt, logic [WORD_W-1:0] pc,
                                          logic [WORD_W-1:0] mp, logic [REG_W-1:0] gp);
    stack_req_t r;
    r.op          = op;
    r.push_value  = pv;
    r.call_target = tgt;
    r.current_pc  = pc;
    r.m_pair      = mp;
    r.gp_regs     = gp;
    return r;
  endfunction

  function automatic int idle_length();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) return 0;
    if (pick < 80) return $urandom_range(1, 3);
    if (pick < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(string what, logic [REG_W-1:0] got, logic [REG_W-1:0] want);
    $display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, want);
    error_count++;
  endtask

  task automatic compare_field(string what, logic [REG_W-1:0] got, logic [REG_W-1:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  task automatic send_request(stack_req_t r);
    int gap;
    @(negedge clk);
    cmd_ch.valid       = 1'b1;
    cmd_ch.op          = r.op;
    cmd_ch.push_value  = r.push_value;
    cmd_ch.call_target = r.call_target;
    cmd_ch.current_pc  = r.current_pc;
    cmd_ch.m_pair_in   = r.m_pair;
    cmd_ch.gp_regs_in  = r.gp_regs;
    do @(posedge clk); while (cmd_ch.ready !== 1'b1);
    pending_results.push_back(stack_step(r));
    if (source_gaps_on) begin
      gap = idle_length();
      if (gap > 0) begin
        @(negedge clk);
        cmd_ch.valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  task automatic send_random_request();
    stack_req_t r;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      r.op = csru_pkg::OP_PUSH;
    end else if (pick < 50) begin
      r.op = (loose_bytes == 0 && $urandom_range(0, 9) != 0) ? csru_pkg::OP_PUSH
                                                              : csru_pkg::OP_POP;
    end else if (pick < 72) begin
      r.op = csru_pkg::OP_CALL;
    end else begin
      r.op = (loose_per_frame.size() == 0 && $urandom_range(0, 9) != 0) ? csru_pkg::OP_CALL
                                                                         : csru_pkg::OP_RET;
    end
    if (r.op == csru_pkg::OP_POP && !stored(shadow_sp, 1)) r.op = csru_pkg::OP_PUSH;
    if (r.op == csru_pkg::OP_RET && !stored(shadow_bp, FRAME_BYTES)) r.op = csru_pkg::OP_CALL;
    case (r.op)
      csru_pkg::OP_PUSH: loose_bytes++;
      csru_pkg::OP_POP: if (loose_bytes > 0) loose_bytes--;
      csru_pkg::OP_CALL: begin
        loose_per_frame.push_back(loose_bytes);
        loose_bytes = 0;
      end
      csru_pkg::OP_RET:
        loose_bytes = (loose_per_frame.size() > 0) ? loose_per_frame.pop_back() : 0;
      default: begin
      end
    endcase
    r.push_value  = BYTE_W'($urandom_range(0, 255));
    r.call_target = WORD_W'($urandom_range(0, 65535));
    r.current_pc  = WORD_W'($urandom_range(0, 65535));
    r.m_pair      = WORD_W'($urandom_range(0, 65535));
    r.gp_regs     = {$urandom(), $urandom()};
    send_request(r);
  endtask

  task automatic test_push_pop_wrap();
    send_request(make_req(csru_pkg::OP_PUSH, 8'h00, 16'h0000, 16'h0000, 16'h0000, '0));
    send_request(make_req(csru_pkg::OP_PUSH, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, '1));
    send_request(make_req(csru_pkg::OP_POP, 8'h00, 16'h1234, 16'h5678, 16'h9ABC,
                          64'h0123_4567_89AB_CDEF));
    send_request(make_req(csru_pkg::OP_POP, 8'hFF, 16'hFFFF, 16'h0000, 16'hFFFF, '0));
  endtask

  task automatic test_nested_calls();
    send_request(make_req(csru_pkg::OP_CALL, 8'h00, 16'hFFFF, 16'h0000, 16'h0000, '0));
    send_request(make_req(csru_pkg::OP_PUSH, 8'hA5, 16'h0000, 16'h0001, 16'h0002, '0));
    send_request(make_req(csru_pkg::OP_CALL, 8'hFF, 16'h0000, 16'hFFFF, 16'hFFFF, '1));
    send_request(make_req(csru_pkg::OP_PUSH, 8'h3C, 16'h0000, 16'h0000, 16'h0000, '0));
    send_request(make_req(csru_pkg::OP_PUSH, 8'hC3, 16'h0000, 16'h0000, 16'h0000, '0));
    send_request(make_req(csru_pkg::OP_RET, 8'h00, 16'hAAAA, 16'h5555, 16'h0F0F,
                          64'h0123_4567_89AB_CDEF));
    send_request(make_req(csru_pkg::OP_POP, 8'h00, 16'h0000, 16'h0000, 16'h0000, '1));
    send_request(make_req(csru_pkg::OP_RET, 8'hFF, 16'h5555, 16'hAAAA, 16'hF0F0,
                          64'hFEDC_BA98_7654_3210));
  endtask

  task automatic test_frame_across_wrap();
    send_request(make_req(csru_pkg::OP_CALL, 8'h00, 16'h8001, 16'hBEEF, 16'h1234,
                          {$urandom(), $urandom()}));
    send_request(make_req(csru_pkg::OP_PUSH, 8'h5A, 16'h0000, 16'h0000, 16'h0000, '0));
    send_request(make_req(csru_pkg::OP_POP, 8'h00, 16'h0000, 16'h0000, 16'h0000, '0));
    send_request(make_req(csru_pkg::OP_RET, 8'h00, 16'h0000, 16'h0000, 16'h0000,
                          {$urandom(), $urandom()}));
  endtask

  // overwrite the saved base pointer so that it points at its own frame
  task automatic test_return_without_call();
    send_request(make_req(csru_pkg::OP_CALL, 8'h00, 16'h4321, 16'hCAFE, 16'h5AA5,
                          {$urandom(), $urandom()}));
    repeat (FRAME_BYTES)
      send_request(make_req(csru_pkg::OP_POP, 8'h00, 16'h0000, 16'h0000, 16'h0000, '0));
    send_request(make_req(csru_pkg::OP_PUSH, shadow_bp[7:0], 16'h0000, 16'h0000,
                          16'h0000, '0));
    send_request(make_req(csru_pkg::OP_PUSH, shadow_bp[15:8], 16'h0000, 16'h0000,
                          16'h0000, '0));
    send_request(make_req(csru_pkg::OP_RET, 8'h00, 16'hFFFF, 16'h0000, 16'h0000,
                          {$urandom(), $urandom()}));
    send_request(make_req(csru_pkg::OP_RET, 8'h00, 16'hFFFF, 16'h0000, 16'h0000,
                          {$urandom(), $urandom()}));
  endtask

  task automatic test_result_backpressure();
    hold_request = 1'b1;
    source_gaps_on = 1'b0;
    repeat (PRESSURE_COUNT) send_random_request();
    source_gaps_on = 1'b1;
  endtask

  task automatic test_random_mix();
    int mode;
    for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
      mode = $urandom_range(0, 3);
      source_gaps_on = mode[0];
      sink_stalls_on = mode[1];
      repeat (BLOCK_REQUESTS) send_random_request();
    end
  endtask

  initial begin : result_sink
    int hold;
    hold = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold = LONG_HOLD_CYCLES;
      end
      if (hold > 0) begin
        res_ch.ready = 1'b0;
        hold--;
      end else begin
        res_ch.ready = 1'b1;
        if (sink_stalls_on && $urandom_range(0, 3) == 0) hold = idle_length();
      end
    end
  end

  always @(posedge clk) begin : result_check
    stack_res_t want;
    if (!rst && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request pending", '0, '0);
      end else begin
        want = pending_results.pop_front();
        compare_field("pop_value", REG_W'(res_ch.pop_value), REG_W'(want.pop_value));
        compare_field("next_pc", REG_W'(res_ch.next_pc), REG_W'(want.next_pc));
        compare_field("m_pair_out", REG_W'(res_ch.m_pair_out), REG_W'(want.m_pair));
        compare_field("gp_regs_out", res_ch.gp_regs_out, want.gp_regs);
        compare_field("return_copy", res_ch.return_copy, want.return_copy);
        compare_field("stack_pointer_out", REG_W'(res_ch.stack_pointer_out),
                      REG_W'(want.stack_pointer));
        compare_field("base_pointer_out", REG_W'(res_ch.base_pointer_out),
                      REG_W'(want.base_pointer));
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    cmd_ch.valid       = 1'b0;
    cmd_ch.op          = csru_pkg::OP_PUSH;
    cmd_ch.push_value  = '0;
    cmd_ch.call_target = '0;
    cmd_ch.current_pc  = '0;
    cmd_ch.m_pair_in   = '0;
    cmd_ch.gp_regs_in  = '0;
    rst = 1'b1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_push_pop_wrap();
    test_nested_calls();
    test_frame_across_wrap();
    test_return_without_call();
    test_result_backpressure();
    test_random_mix();

    @(negedge clk);
    cmd_ch.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch("requests left without a result", REG_W'(pending_results.size()), '0);

    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
